### design/itoa_pkg.sv
package itoa_pkg;

    // format selectors
    localparam logic [2:0] CMD_DEC      = 3'd0;
    localparam logic [2:0] CMD_DEC4     = 3'd1;
    localparam logic [2:0] CMD_BIN_TRIM = 3'd2;
    localparam logic [2:0] CMD_BIN16    = 3'd3;
    localparam logic [2:0] CMD_BIN8     = 3'd4;
    localparam logic [2:0] CMD_HEX      = 3'd5;

    // ASCII codes
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_ONE   = 7'h31;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_A     = 7'h41;

    typedef logic [2:0] t_upc;

    // microprogram addresses
    localparam t_upc UPC_IDLE   = 3'd0;
    localparam t_upc UPC_DABBLE = 3'd1;
    localparam t_upc UPC_SIGN   = 3'd2;
    localparam t_upc UPC_DEC    = 3'd3;
    localparam t_upc UPC_BIN    = 3'd4;
    localparam t_upc UPC_HEX    = 3'd5;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_DABBLE,
        OP_SIGN,
        OP_DEC,
        OP_BIN,
        OP_HEX
    } t_op;

    typedef enum logic [1:0] {
        COND_DISPATCH,
        COND_ALWAYS,
        COND_MORE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  jump;
        t_upc  next;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic step;
    } t_ctl;

    typedef struct packed {
        logic more;
        logic slot_free;
    } t_stat;

    function automatic t_upc dispatch(input logic [2:0] cmd);
        t_upc a;
        unique case (cmd)
            CMD_DEC, CMD_DEC4:                a = UPC_DABBLE;
            CMD_BIN_TRIM, CMD_BIN16, CMD_BIN8: a = UPC_BIN;
            CMD_HEX:                          a = UPC_HEX;
            default:                          a = UPC_IDLE;
        endcase
        return a;
    endfunction

endpackage

### design/itoa_urom.sv
module itoa_urom (
    input  itoa_pkg::t_upc   i_addr,
    output itoa_pkg::t_uword o_word
);
    import itoa_pkg::*;

    always_comb begin
        unique case (i_addr)
            UPC_IDLE:   o_word = '{OP_IDLE,   COND_DISPATCH, UPC_IDLE,   UPC_IDLE};
            UPC_DABBLE: o_word = '{OP_DABBLE, COND_MORE,     UPC_DABBLE, UPC_SIGN};
            UPC_SIGN:   o_word = '{OP_SIGN,   COND_ALWAYS,   UPC_DEC,    UPC_DEC};
            UPC_DEC:    o_word = '{OP_DEC,    COND_MORE,     UPC_DEC,    UPC_IDLE};
            UPC_BIN:    o_word = '{OP_BIN,    COND_MORE,     UPC_BIN,    UPC_IDLE};
            UPC_HEX:    o_word = '{OP_HEX,    COND_MORE,     UPC_HEX,    UPC_IDLE};
            default:    o_word = '{OP_IDLE,   COND_ALWAYS,   UPC_IDLE,   UPC_IDLE};
        endcase
    end

endmodule

### design/itoa_dp.sv
module itoa_dp #(
    parameter int VALUE_BITS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  itoa_pkg::t_ctl  i_ctl,
    input  logic [2:0]      i_cmd,
    input  logic [63:0]     i_value,
    input  logic            i_out_ready,
    output itoa_pkg::t_stat o_stat,
    output logic            o_out_valid,
    output logic [6:0]      o_out_char,
    output logic            o_out_last
);
    import itoa_pkg::*;

    // decimal digits needed for VALUE_BITS bits: floor(bits * log10(2)) + 1
    localparam int ND  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int CW  = $clog2(VALUE_BITS + 1);
    localparam int DIW = $clog2(ND);

    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [ND*4-1:0]       r_bcd, n_bcd;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_neg, n_neg;
    logic                  r_seen, n_seen;
    logic                  r_dec4, n_dec4;
    logic                  r_out_valid, n_out_valid;
    logic [6:0]            r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;

    logic [VALUE_BITS-1:0] w_x, w_mag0;
    logic [15:0]           w_m16;
    logic [ND*4-1:0]       w_adj;
    logic [DIW-1:0]        w_idx;
    logic [3:0]            w_digit;
    logic [3:0]            w_nib;
    logic                  w_cnt_last;
    logic                  w_emit;
    logic [6:0]            w_char;

    assign w_x    = i_value[VALUE_BITS-1:0];
    assign w_mag0 = w_x[VALUE_BITS-1] ? (~w_x + 1'b1) : w_x;
    assign w_m16  = i_value[15] ? (~i_value[15:0] + 16'd1) : i_value[15:0];

    // add-3 correction on every digit before the shift
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            w_adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? r_bcd[i*4 +: 4] + 4'd3
                                                        : r_bcd[i*4 +: 4];
        end
    end

    assign w_idx      = DIW'(r_cnt - CW'(1));
    assign w_digit    = r_bcd[w_idx*4 +: 4];
    assign w_nib      = r_mag[15:12];
    assign w_cnt_last = (r_cnt == CW'(1));

    assign o_stat.more      = !w_cnt_last;
    assign o_stat.slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_seen      = r_seen;
        n_dec4      = r_dec4;
        w_emit      = 1'b0;
        w_char      = CH_ZERO;
        unique case (i_ctl.op)
            OP_IDLE: begin
                n_bcd  = '0;
                n_neg  = 1'b0;
                n_dec4 = (i_cmd == CMD_DEC4);
                n_seen = !((i_cmd == CMD_DEC) || (i_cmd == CMD_BIN_TRIM));
                unique case (i_cmd)
                    CMD_DEC: begin
                        n_mag = w_mag0;
                        n_neg = w_x[VALUE_BITS-1];
                        n_cnt = CW'(VALUE_BITS);
                    end
                    CMD_DEC4: begin
                        n_mag = VALUE_BITS'(w_m16);
                        n_neg = i_value[15];
                        n_cnt = CW'(VALUE_BITS);
                    end
                    CMD_BIN_TRIM, CMD_BIN16: begin
                        n_mag = VALUE_BITS'(i_value[15:0]);
                        n_cnt = CW'(16);
                    end
                    CMD_BIN8: begin
                        n_mag = VALUE_BITS'({i_value[7:0], 8'h00});
                        n_cnt = CW'(8);
                    end
                    CMD_HEX: begin
                        n_mag = VALUE_BITS'({i_value[7:0], 8'h00});
                        n_cnt = CW'(2);
                    end
                    default: begin
                        n_mag = r_mag;
                        n_cnt = r_cnt;
                    end
                endcase
            end
            OP_DABBLE: begin
                n_bcd = {w_adj[ND*4-2:0], r_mag[VALUE_BITS-1]};
                n_mag = r_mag << 1;
                n_cnt = r_cnt - CW'(1);
            end
            OP_SIGN: begin
                w_emit = r_neg;
                w_char = CH_MINUS;
                n_cnt  = r_dec4 ? CW'(4) : CW'(ND);
            end
            OP_DEC: begin
                w_emit = (w_digit != 4'd0) || r_seen || w_cnt_last;
                w_char = CH_ZERO + 7'(w_digit);
                if (w_digit != 4'd0) begin
                    n_seen = 1'b1;
                end
                n_cnt = r_cnt - CW'(1);
            end
            OP_BIN: begin
                w_emit = r_mag[15] || r_seen || w_cnt_last;
                w_char = r_mag[15] ? CH_ONE : CH_ZERO;
                if (r_mag[15]) begin
                    n_seen = 1'b1;
                end
                n_mag = r_mag << 1;
                n_cnt = r_cnt - CW'(1);
            end
            OP_HEX: begin
                w_emit = 1'b1;
                w_char = (w_nib < 4'd10) ? CH_ZERO + 7'(w_nib) : CH_A + 7'(w_nib - 4'd10);
                n_mag  = r_mag << 4;
                n_cnt  = r_cnt - CW'(1);
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (i_ctl.step && w_emit) begin
            n_out_valid = 1'b1;
            n_out_char  = w_char;
            n_out_last  = (i_ctl.op != OP_SIGN) && w_cnt_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        if (i_ctl.step) begin
            r_mag  <= n_mag;
            r_bcd  <= n_bcd;
            r_cnt  <= n_cnt;
            r_neg  <= n_neg;
            r_seen <= n_seen;
            r_dec4 <= n_dec4;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

### design/integer_to_ascii_formatter_unit.sv
// Integer to ASCII formatter.
// Input stream: one word per number; tuser selects the format (0 signed
// decimal, 1 four-digit decimal, 2 trimmed binary, 3 binary 16, 4 binary 8,
// 5 hex byte), tdata carries the 64-bit value. Selectors 6 and 7 are taken
// and produce nothing.
// Output stream: one ASCII character per word, most significant first,
// tlast on the final character of the number.
// A small microprogram steps the datapath. Decimal formats run a shift-add-3
// binary-to-BCD loop over the VALUE_BITS bits of the magnitude, then one
// sign step, then a step per BCD digit (floor(VALUE_BITS*log10(2))+1 of
// them for signed decimal, leading zeros skipped, four for the fixed
// format). Binary steps through 16 (or 8) bits, hex through 2 nibbles.
// Each character is registered before it leaves.
// One number is in flight at a time; s_axis_tready is high only while the
// sequencer waits at its idle step.
// Characters go through a single output register; when the receiver stalls
// the sequencer holds its output steps until that register frees.
// Reset returns the sequencer to idle and empties the output register.
module integer_to_ascii_formatter_unit #(
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    input  logic [2:0]  s_axis_tuser,   // [2:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] character, [7] zero
    output logic        m_axis_tlast
);
    import itoa_pkg::*;

    t_upc   r_pc, n_pc;
    t_uword w_word;
    t_ctl   w_ctl;
    t_stat  w_stat;
    logic [6:0] w_char;

    itoa_urom u_urom (
        .i_addr (r_pc),
        .o_word (w_word)
    );

    itoa_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_cmd       (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (w_char),
        .o_out_last  (m_axis_tlast)
    );

    always_comb begin
        w_ctl.op = w_word.op;
        unique case (w_word.op)
            OP_IDLE:   w_ctl.step = s_axis_tvalid;
            OP_DABBLE: w_ctl.step = 1'b1;
            default:   w_ctl.step = w_stat.slot_free;
        endcase

        n_pc = r_pc;
        if (w_ctl.step) begin
            unique case (w_word.cond)
                COND_DISPATCH: n_pc = dispatch(s_axis_tuser);
                COND_ALWAYS:   n_pc = w_word.jump;
                COND_MORE:     n_pc = w_stat.more ? w_word.jump : w_word.next;
                default:       n_pc = UPC_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UPC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign s_axis_tready = (w_word.op == OP_IDLE);
    assign m_axis_tdata  = {1'b0, w_char};

endmodule
